>>> rtl/core/wapc_pkg.sv
// Shared types, constants and arithmetic helpers for the window average
// prediction check core. No dependencies.
`timescale 1ns / 1ps

package wapc_pkg;

  // Window geometry.
  localparam int WINDOW_SIZE = 5;
  localparam int DATA_W      = 16;
  localparam int SLOT_W      = $clog2(WINDOW_SIZE);
  localparam int SUM_W       = DATA_W + $clog2(WINDOW_SIZE);

  // Exact divide by the window size through a rounded-up reciprocal.
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_SIZE);
  localparam int DIV_MULT_W = SUM_W + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
      DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

  // Prediction budget: (period + 60) / 60, also through a reciprocal.
  localparam int PERIOD_UNIT = 60;
  localparam int PER_W       = DATA_W + 1;
  localparam int PER_SHIFT   = PER_W + $clog2(PERIOD_UNIT);
  localparam int PER_MULT_W  = PER_W + 1;
  localparam logic [PER_MULT_W-1:0] PER_MULT =
      PER_MULT_W'(((64'd1 << PER_SHIFT) + 64'(PERIOD_UNIT) - 64'd1) / 64'(PERIOD_UNIT));

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIR_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd2;

  localparam logic [DATA_W-1:0] GOOD_THRESHOLD_RST = 16'd1;
  localparam logic [DATA_W-1:0] FAIR_THRESHOLD_RST = 16'd3;
  localparam logic [DATA_W-1:0] OWN_ADDRESS_RST    = 16'd256;
  localparam logic [DATA_W-1:0] PACKET_COUNT_RST   = 16'd1;
  localparam logic [DATA_W-1:0] PACKET_COUNT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    VERDICT_FAIR = 2'd0,
    VERDICT_GOOD = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_e;

  // Write request into the sample window.
  typedef struct packed {
    logic              wr_en;
    logic              upd_avg;
    logic [DATA_W-1:0] data;
  } win_cmd_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0] average;
    verdict_e          verdict;
    logic              reply_send;
    logic [DATA_W-1:0] reply_address;
    logic              prediction_made;
    logic [DATA_W-1:0] predicted_value;
  } result_t;

  function automatic logic [DATA_W-1:0] div_window(input logic [SUM_W-1:0] sum);
    logic [SUM_W+DIV_MULT_W-1:0] prod;
    prod = SUM_W'(sum) * DIV_MULT;
    return prod[DIV_SHIFT +: DATA_W];
  endfunction

  // The quotient is at most 1093, so the bits above the product's top are zero.
  function automatic logic [DATA_W-1:0] budget_from_period(input logic [DATA_W-1:0] period);
    logic [PER_W-1:0]            num;
    logic [PER_W+PER_MULT_W-1:0] prod;
    num  = {1'b0, period} + PER_W'(PERIOD_UNIT);
    prod = num * PER_MULT;
    return DATA_W'(prod[PER_W+PER_MULT_W-1:PER_SHIFT]);
  endfunction

endpackage

>>> rtl/core/wapc_window.sv
// Ring of window samples with slot pointer and registered average.
// Depends on wapc_pkg.
`timescale 1ns / 1ps

module wapc_window import wapc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  win_cmd_t          cmd_i,
  output logic [DATA_W-1:0] avg_cur_o,
  output logic [DATA_W-1:0] avg_next_o
);

  logic [DATA_W-1:0] win_q [WINDOW_SIZE];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [DATA_W-1:0] avg_q;
  logic [SUM_W-1:0]  sum;

  assign slot_d = (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + SLOT_W'(1);

  // Sum of the window as it will be after the write.
  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (cmd_i.wr_en && (slot_d == SLOT_W'(i))) begin
        sum = sum + SUM_W'(cmd_i.data);
      end else begin
        sum = sum + SUM_W'(win_q[i]);
      end
    end
  end

  assign avg_next_o = div_window(sum);
  assign avg_cur_o  = avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      avg_q  <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cmd_i.wr_en) begin
        slot_q        <= slot_d;
        win_q[slot_d] <= cmd_i.data;
      end
      if (cmd_i.upd_avg) begin
        avg_q <= avg_next_o;
      end
    end
  end

endmodule

>>> rtl/core/wapc_ctrl.sv
// Configuration registers, classification, prediction budget and packet
// bookkeeping. Depends on wapc_pkg.
`timescale 1ns / 1ps

module wapc_ctrl import wapc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 accept_i,
  input  logic                 mode_i,
  input  logic [DATA_W-1:0]    temperature_i,
  input  logic [DATA_W-1:0]    period_seconds_i,
  input  logic [DATA_W-1:0]    sender_address_i,
  input  logic [DATA_W-1:0]    avg_cur_i,
  input  logic [DATA_W-1:0]    avg_next_i,
  output win_cmd_t             win_cmd_o,
  output result_t              result_o
);

  logic [DATA_W-1:0] good_q, fair_q, own_q;
  verdict_e          verdict_q, verdict_d;
  logic [DATA_W-1:0] budget_q, budget_d;
  logic [DATA_W-1:0] period_q, period_d;
  logic [DATA_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] sender_q, sender_d;

  logic signed [DATA_W:0] diff_s;
  logic [DATA_W-1:0]      budget_new, budget_sel, count_inc;
  logic                   act_tick, count_ready;
  verdict_e               verdict_new;

  assign diff_s = signed'({1'b0, temperature_i}) - signed'({1'b0, avg_next_i});

  always_comb begin
    if (diff_s <= signed'({1'b0, good_q})) begin
      verdict_new = VERDICT_GOOD;
    end else if (diff_s <= signed'({1'b0, fair_q})) begin
      verdict_new = VERDICT_FAIR;
    end else begin
      verdict_new = VERDICT_BAD;
    end
  end

  assign act_tick    = sender_q != own_q;
  assign count_ready = count_q >= DATA_W'(WINDOW_SIZE);
  assign count_inc   = (count_q != PACKET_COUNT_MAX) ? count_q + DATA_W'(1) : count_q;
  assign budget_new  = budget_from_period(period_q);
  assign budget_sel  = (verdict_q == VERDICT_GOOD) ? budget_new : budget_q;

  always_comb begin
    verdict_d = verdict_q;
    budget_d  = budget_q;
    period_d  = period_q;
    count_d   = count_q;
    sender_d  = sender_q;
    win_cmd_o = '0;
    result_o  = '0;
    result_o.average = avg_cur_i;
    result_o.verdict = verdict_q;
    if (accept_i) begin
      if (!mode_i) begin
        period_d          = period_seconds_i;
        sender_d          = sender_address_i;
        verdict_d         = verdict_new;
        win_cmd_o.wr_en   = 1'b1;
        win_cmd_o.upd_avg = 1'b1;
        win_cmd_o.data    = temperature_i;
        result_o.average  = avg_next_i;
        result_o.verdict  = verdict_new;
      end else if (act_tick) begin
        if (count_ready) begin
          budget_d = budget_sel;
          // A nonzero budget inserts the current average as a sample.
          if (budget_sel != '0) begin
            budget_d                 = budget_sel - DATA_W'(1);
            win_cmd_o.wr_en          = 1'b1;
            win_cmd_o.data           = avg_cur_i;
            result_o.prediction_made = 1'b1;
            result_o.predicted_value = avg_cur_i;
          end
        end
        count_d                = count_inc;
        result_o.reply_send    = count_inc >= DATA_W'(WINDOW_SIZE);
        result_o.reply_address = sender_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q    <= GOOD_THRESHOLD_RST;
      fair_q    <= FAIR_THRESHOLD_RST;
      own_q     <= OWN_ADDRESS_RST;
      verdict_q <= VERDICT_FAIR;
      budget_q  <= '0;
      period_q  <= '0;
      count_q   <= PACKET_COUNT_RST;
      sender_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_GOOD_THRESHOLD: good_q <= cfg_wdata_i;
          CFG_FAIR_THRESHOLD: fair_q <= cfg_wdata_i;
          CFG_OWN_ADDRESS:    own_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      verdict_q <= verdict_d;
      budget_q  <= budget_d;
      period_q  <= period_d;
      count_q   <= count_d;
      sender_q  <= sender_d;
    end
  end

endmodule

>>> rtl/core/window_average_prediction_check_core.sv
// Top level of the window average prediction check core: handshake,
// result register and the window and control units. Depends on wapc_pkg,
// wapc_window and wapc_ctrl.
`timescale 1ns / 1ps

// Every accepted item produces exactly one result item the cycle after, and
// a new item can be accepted in every cycle: the whole update (window write,
// five-entry sum, reciprocal divide by the window size, classification and
// tick bookkeeping) is one pass of logic between the item on the input ports
// and the result register. A sample item (mode 0) stores the temperature in
// the next ring slot, recomputes the average and classes the signed
// difference temperature minus average as good, fair or bad against the two
// thresholds. A tick item (mode 1) acts only when the last sender differs
// from own_address; once enough packets have been counted it may refresh
// the prediction budget from the last sensor period and insert the current
// average into the window as a predicted sample, then it counts the packet
// and may raise reply_send. The single result register decouples the sides:
// in_stall_o is high only while a result is held and out_stall_i is high,
// so the input keeps flowing as long as results are taken. Configuration
// writes go through cfg_we_i, cfg_index_i and cfg_wdata_i and are meant to
// happen while no item is in flight; index 3 is ignored.
module window_average_prediction_check_core import wapc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [DATA_W-1:0]    temperature_i,
  input  logic [DATA_W-1:0]    period_seconds_i,
  input  logic [DATA_W-1:0]    sender_address_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    average_o,
  output logic [1:0]           verdict_o,
  output logic                 reply_send_o,
  output logic [DATA_W-1:0]    reply_address_o,
  output logic                 prediction_made_o,
  output logic [DATA_W-1:0]    predicted_value_o
);

  logic              accept;
  logic              out_valid_q, out_valid_d;
  result_t           result, result_q;
  win_cmd_t          win_cmd;
  logic [DATA_W-1:0] avg_cur, avg_next;

  // The result register can take a new item when it is empty or drains now.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  wapc_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (win_cmd),
    .avg_cur_o  (avg_cur),
    .avg_next_o (avg_next)
  );

  wapc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .temperature_i    (temperature_i),
    .period_seconds_i (period_seconds_i),
    .sender_address_i (sender_address_i),
    .avg_cur_i        (avg_cur),
    .avg_next_i       (avg_next),
    .win_cmd_o        (win_cmd),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_o         = result_q.average;
  assign verdict_o         = result_q.verdict;
  assign reply_send_o      = result_q.reply_send;
  assign reply_address_o   = result_q.reply_address;
  assign prediction_made_o = result_q.prediction_made;
  assign predicted_value_o = result_q.predicted_value;

  // An accepted item always leaves a result in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item did not produce a result");

  // A prediction is only made once enough packets passed, so a reply follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.prediction_made) |-> result_q.reply_send)
    else $error("prediction made without reply");

  // A tick does not recompute the sum, so the inserted value is the average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.prediction_made) |->
      (result_q.predicted_value == result_q.average))
    else $error("predicted value differs from the average");

  // Without a prediction the predicted value reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.prediction_made) |-> (result_q.predicted_value == '0))
    else $error("predicted value set without a prediction");

endmodule
